// File: rtl/core/moa_pkg.sv
// Shared types and constants for the morph offset accumulator.
package moa_pkg;

	localparam int OFF_W = 16;
	localparam int SUM_W = 24;
	localparam int PROD_W = 32;
	localparam int CNT_W = 13;
	localparam int IDX_W = 12;
	localparam int SDATA_W = 80;
	localparam int MDATA_W = 80;

	localparam logic [1:0] ACT_BEGIN = 2'd0;
	localparam logic [1:0] ACT_ACC = 2'd1;
	localparam logic [1:0] ACT_READ = 2'd2;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_RANGE = 2'd1;
	localparam logic [1:0] STAT_SAT = 2'd2;

	localparam logic signed [PROD_W-1:0] ROUND_HALF = 32'sd8192;
	localparam logic signed [SUM_W-1:0] SUM_MAX = 24'sh7FFFFF;
	localparam logic signed [SUM_W-1:0] SUM_MIN = 24'sh800000;

	typedef logic signed [OFF_W-1:0] off_t;
	typedef logic signed [SUM_W-1:0] sum_t;
	typedef logic signed [PROD_W-1:0] prod_t;

endpackage

// File: rtl/core/moa_ram.sv
// Generic single-port-write, registered-read synchronous RAM.
module moa_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/moa_lane.sv
// One offset component: registered weight product, rounding, saturating add.
module moa_lane (
	input  logic          clk,
	input  logic          mul_en,
	input  moa_pkg::off_t offset,
	input  moa_pkg::off_t weight,
	input  moa_pkg::sum_t sum_in,
	output moa_pkg::sum_t sum_out,
	output logic          sat
);

	import moa_pkg::*;

	prod_t               prod_s1;
	prod_t               rnd;
	logic signed [17:0]  q12;
	logic signed [24:0]  total;

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_s1 <= offset * weight;
		end
	end

	always_comb begin
		rnd = prod_s1 + ROUND_HALF;
		q12 = rnd[31:14];
		total = 25'(sum_in) + 25'(q12);
		sat = total[24] != total[23];
		if (!sat) begin
			sum_out = total[23:0];
		end else if (total[24]) begin
			sum_out = SUM_MIN;
		end else begin
			sum_out = SUM_MAX;
		end
	end

endmodule

// File: rtl/core/morph_offset_accumulator_core.sv
// Top level of the morph offset accumulator: control, register port and memory.
// Each transaction is accepted in the idle state; the memory read of the vertex entry is
// registered on acceptance, the multiply state registers the weight products, and the add
// state rounds, does the saturating add and the write-back. A new transaction is accepted
// only once the previous result has a place in the output register. A begin transaction,
// and reset, start a clearing pass that zeroes MAX_VERTICES memory entries, one per cycle;
// no transaction is accepted during the pass, while register writes are taken as usual.
module morph_offset_accumulator_core #(
	parameter int MAX_VERTICES = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// vertex_index, offset_x, offset_y, offset_z, weight, zero fill
	input  logic [moa_pkg::SDATA_W-1:0] s_tdata,
	// action
	input  logic [1:0]                  s_tuser,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// sum_x, sum_y, sum_z, any_active, zero fill
	output logic [moa_pkg::MDATA_W-1:0] m_tdata,
	// status
	output logic [1:0]                  m_tuser,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	import moa_pkg::*;

	localparam int AW = $clog2(MAX_VERTICES);

	typedef enum logic [1:0] {
		S_CLR,
		S_IDLE,
		S_MUL,
		S_ADD
	} state_t;

	state_t             state_q;
	logic [AW-1:0]      clr_q;
	logic               flag_q;
	logic [CNT_W-1:0]   count_q;

	logic [1:0]         act_q;
	logic [AW-1:0]      addr_q;
	logic               valid_q;
	off_t               off_q [3];
	off_t               w_q;
	logic [MDATA_W-1:0] out_data_q;
	logic [1:0]         out_stat_q;

	logic               s_acc;
	logic [IDX_W-1:0]   s_idx;
	logic [31:0]        s_idx_ext;
	logic               s_valid;
	logic               out_free;
	logic               do_wr;
	logic               any_sat;
	logic               flag_nxt;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [3*SUM_W-1:0] ram_wdata;
	logic [3*SUM_W-1:0] ram_rdata;
	sum_t               old_sum [3];
	sum_t               new_sum [3];
	logic [2:0]         sat;
	sum_t               res_sum [3];
	logic [1:0]         res_stat;
	logic               cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = paddr[2] ? 32'd0 : 32'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_wr && !paddr[2]) begin
			count_q <= pwdata[CNT_W-1:0];
		end
	end

	assign s_tready = state_q == S_IDLE;
	assign s_acc = s_tvalid && s_tready;
	assign s_idx = s_tdata[IDX_W-1:0];
	assign s_idx_ext = 32'(s_idx);
	assign s_valid = (s_idx_ext < 32'(count_q)) && (s_idx_ext < 32'(MAX_VERTICES));
	assign out_free = !m_tvalid || m_tready;
	assign do_wr = act_q == ACT_ACC && valid_q && w_q != '0;
	assign any_sat = |sat;

	always_comb begin
		unique case (act_q)
			ACT_BEGIN: flag_nxt = 1'b0;
			default:   flag_nxt = flag_q || do_wr;
		endcase
	end

	moa_ram #(
		.WIDTH(3 * SUM_W),
		.DEPTH(MAX_VERTICES)
	) u_sums (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (s_acc),
		.raddr(s_idx_ext[AW-1:0]),
		.rdata(ram_rdata)
	);

	assign ram_we = state_q == S_CLR || (state_q == S_ADD && out_free && do_wr);
	assign ram_waddr = state_q == S_CLR ? clr_q : addr_q;
	assign ram_wdata = state_q == S_CLR ? '0 : {new_sum[2], new_sum[1], new_sum[0]};

	for (genvar k = 0; k < 3; k++) begin : g_lane
		assign old_sum[k] = ram_rdata[k*SUM_W +: SUM_W];

		moa_lane u_lane (
			.clk    (clk),
			.mul_en (state_q == S_MUL),
			.offset (off_q[k]),
			.weight (w_q),
			.sum_in (old_sum[k]),
			.sum_out(new_sum[k]),
			.sat    (sat[k])
		);
	end

	always_comb begin
		res_stat = STAT_OK;
		for (int k = 0; k < 3; k++) begin
			res_sum[k] = '0;
		end
		if (act_q == ACT_ACC || act_q == ACT_READ) begin
			if (!valid_q) begin
				res_stat = STAT_RANGE;
			end else if (do_wr) begin
				res_sum = new_sum;
				res_stat = any_sat ? STAT_SAT : STAT_OK;
			end else begin
				res_sum = old_sum;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			flag_q <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (m_tvalid && m_tready && !(state_q == S_ADD && out_free)) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(MAX_VERTICES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_acc) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						flag_q <= flag_nxt;
						clr_q <= '0;
						state_q <= act_q == ACT_BEGIN ? S_CLR : S_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			act_q <= s_tuser;
			addr_q <= s_idx_ext[AW-1:0];
			valid_q <= s_valid;
			off_q[0] <= s_tdata[27:12];
			off_q[1] <= s_tdata[43:28];
			off_q[2] <= s_tdata[59:44];
			w_q <= s_tdata[75:60];
		end
		if (state_q == S_ADD && out_free) begin
			out_data_q <= {7'd0, flag_nxt, res_sum[2], res_sum[1], res_sum[0]};
			out_stat_q <= res_stat;
		end
	end

	assign m_tdata = out_data_q;
	assign m_tuser = out_stat_q;

endmodule

// File: rtl/core/moa_checker.sv
// Port-level assertions for the morph offset accumulator, bound to the top level.
module moa_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic [moa_pkg::MDATA_W-1:0] m_tdata,
	input logic [1:0]                  m_tuser,
	input logic                        m_tvalid,
	input logic                        m_tready
);

	import moa_pkg::*;

	// one transaction in flight: hold off the next one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second transaction accepted while one is in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed or dropped");

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STAT_RANGE |-> m_tdata[3*SUM_W-1:0] == '0)
		else $error("out-of-range result carries nonzero sums");

	a_sat_active: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STAT_SAT |-> m_tdata[3*SUM_W])
		else $error("saturated result without active flag");

endmodule

bind morph_offset_accumulator_core moa_checker u_moa_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready)
);
